[rtl/ocd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_pkg
// Shared types, command codes and helpers of the OLED command decoder.
// ----------------------------------------------------------------------------
package ocd_pkg;

  localparam int COLUMNS_DEFAULT = 128;

  localparam logic [3:0] PAGE_COUNT_RESET = 4'd8;
  localparam logic [8:0] PERIOD_RESET     = 9'd5;

  // Item codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_STOP = 1'b1;

  // Addressing modes (anything else behaves as page mode)
  localparam logic [7:0] MODE_HORIZONTAL = 8'h00;
  localparam logic [7:0] MODE_VERTICAL   = 8'h01;

  // Command codes
  localparam logic [7:0] CMD_COL_LOW_FIRST  = 8'h00;
  localparam logic [7:0] CMD_COL_LOW_LAST   = 8'h0F;
  localparam logic [7:0] CMD_COL_HIGH_FIRST = 8'h10;
  localparam logic [7:0] CMD_COL_HIGH_LAST  = 8'h1F;
  localparam logic [7:0] CMD_ADDR_MODE      = 8'h20;
  localparam logic [7:0] CMD_COL_WINDOW     = 8'h21;
  localparam logic [7:0] CMD_PAGE_WINDOW    = 8'h22;
  localparam logic [7:0] CMD_VSCROLL_AREA   = 8'hA3;
  localparam logic [7:0] CMD_SCROLL_RIGHT   = 8'h26;
  localparam logic [7:0] CMD_SCROLL_LEFT    = 8'h27;
  localparam logic [7:0] CMD_SCROLL_VRIGHT  = 8'h29;
  localparam logic [7:0] CMD_SCROLL_VLEFT   = 8'h2A;
  localparam logic [7:0] CMD_SCROLL_STOP    = 8'h2E;
  localparam logic [7:0] CMD_SCROLL_START   = 8'h2F;
  localparam logic [7:0] CMD_LINE_FIRST     = 8'h40;
  localparam logic [7:0] CMD_LINE_LAST      = 8'h7F;
  localparam logic [7:0] CMD_CONTRAST       = 8'h81;
  localparam logic [7:0] CMD_CHARGE_PUMP    = 8'h8D;
  localparam logic [7:0] CMD_MUX_RATIO      = 8'hA8;
  localparam logic [7:0] CMD_DISP_OFFSET    = 8'hD3;
  localparam logic [7:0] CMD_CLOCK_DIV      = 8'hD5;
  localparam logic [7:0] CMD_PRECHARGE      = 8'hD9;
  localparam logic [7:0] CMD_COM_PINS       = 8'hDA;
  localparam logic [7:0] CMD_VCOM_LEVEL     = 8'hDB;
  localparam logic [7:0] CMD_FOLLOW_RAM     = 8'hA4;
  localparam logic [7:0] CMD_ALL_ON         = 8'hA5;
  localparam logic [7:0] CMD_NORMAL         = 8'hA6;
  localparam logic [7:0] CMD_INVERT         = 8'hA7;
  localparam logic [7:0] CMD_DISPLAY_OFF    = 8'hAE;
  localparam logic [7:0] CMD_DISPLAY_ON     = 8'hAF;
  localparam logic [7:0] CMD_PAGE_FIRST     = 8'hB0;
  localparam logic [7:0] CMD_PAGE_LAST      = 8'hB7;

  // Argument counts
  localparam logic [2:0] ARGS_ONE       = 3'd1;
  localparam logic [2:0] ARGS_WINDOW    = 3'd2;
  localparam logic [2:0] ARGS_HSCROLL   = 3'd6;
  localparam logic [2:0] ARGS_VSCROLL   = 3'd5;
  // Remaining count at which the interval argument arrives
  localparam logic [2:0] AT_HSCROLL_IVL = 3'd4;
  localparam logic [2:0] AT_VSCROLL_IVL = 3'd3;

  typedef struct packed {
    logic       opcode;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic       ram_write;
    logic [6:0] write_column;
    logic [2:0] write_page;
    logic [7:0] write_data;
    logic       display_on;
    logic       display_full;
    logic       display_inverted;
    logic [5:0] start_line;
    logic       scroll_active;
    logic       scroll_right;
    logic       scroll_vertical;
    logic [8:0] scroll_interval;
  } rsp_t;

  // Highest page index for a page count, count clamped to 2..8
  function automatic logic [2:0] last_page(input logic [3:0] count);
    logic [2:0] r;
    if (count < 4'd2) begin
      r = 3'd1;
    end else if (count > 4'd8) begin
      r = 3'd7;
    end else begin
      r = 3'(count - 4'd1);
    end
    return r;
  endfunction

  // Frames between scroll steps
  function automatic logic [8:0] scroll_frames(input logic [2:0] code);
    logic [8:0] r;
    case (code)
      3'd0:    r = 9'd5;
      3'd1:    r = 9'd64;
      3'd2:    r = 9'd128;
      3'd3:    r = 9'd256;
      3'd4:    r = 9'd3;
      3'd5:    r = 9'd4;
      3'd6:    r = 9'd25;
      default: r = 9'd2;
    endcase
    return r;
  endfunction

endpackage

[rtl/ocd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_ctrl
// Mode tracking, command decode and pointer update for one bus byte.
// ----------------------------------------------------------------------------
module ocd_ctrl #(
  parameter int COLUMNS = ocd_pkg::COLUMNS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  ocd_pkg::req_t item,
  input  logic [3:0]    page_count,
  output ocd_pkg::rsp_t result
);

  localparam logic [6:0] ColLast = 7'(COLUMNS - 1);

  logic       cmd_mode, cmd_mode_next;
  logic       data_mode, data_mode_next;
  logic       cont, cont_next;
  logic [2:0] pending, pending_next;
  logic [7:0] last_cmd, last_cmd_next;
  logic [7:0] addr_mode, addr_mode_next;
  logic [6:0] col_ptr, col_ptr_next;
  logic [2:0] page_ptr, page_ptr_next;
  logic [6:0] col_start, col_start_next;
  logic [6:0] col_end, col_end_next;
  logic [2:0] page_start, page_start_next;
  logic [2:0] page_end, page_end_next;
  logic [8:0] period, period_next;
  logic [5:0] line_start, line_start_next;
  logic       flag_on, flag_on_next;
  logic       flag_full, flag_full_next;
  logic       flag_invert, flag_invert_next;
  logic       flag_scroll, flag_scroll_next;
  logic       flag_right, flag_right_next;
  logic       flag_vert, flag_vert_next;

  logic [7:0] b;
  logic       wr;
  logic [7:0] col_adv;
  logic [3:0] page_adv;
  logic [2:0] page_lim;

  assign b        = item.byte_value;
  assign page_lim = ocd_pkg::last_page(page_count);

  // Pointer step after a display write
  always_comb begin
    col_adv  = {1'b0, col_ptr};
    page_adv = {1'b0, page_ptr};
    if (addr_mode == ocd_pkg::MODE_VERTICAL) begin
      page_adv = page_adv + 4'd1;
      if (page_adv > {1'b0, page_end}) begin
        page_adv = {1'b0, page_start};
        col_adv  = col_adv + 8'd1;
      end
      if (col_adv > {1'b0, col_end}) begin
        col_adv = {1'b0, col_start};
      end
    end else begin
      col_adv = col_adv + 8'd1;
      if (col_adv > {1'b0, col_end}) begin
        col_adv = {1'b0, col_start};
        if (addr_mode == ocd_pkg::MODE_HORIZONTAL) begin
          page_adv = page_adv + 4'd1;
        end
      end
      if (addr_mode == ocd_pkg::MODE_HORIZONTAL && page_adv > {1'b0, page_end}) begin
        page_adv = {1'b0, page_start};
      end
    end
  end

  always_comb begin
    cmd_mode_next    = cmd_mode;
    data_mode_next   = data_mode;
    cont_next        = cont;
    pending_next     = pending;
    last_cmd_next    = last_cmd;
    addr_mode_next   = addr_mode;
    col_ptr_next     = col_ptr;
    page_ptr_next    = page_ptr;
    col_start_next   = col_start;
    col_end_next     = col_end;
    page_start_next  = page_start;
    page_end_next    = page_end;
    period_next      = period;
    line_start_next  = line_start;
    flag_on_next     = flag_on;
    flag_full_next   = flag_full;
    flag_invert_next = flag_invert;
    flag_scroll_next = flag_scroll;
    flag_right_next  = flag_right;
    flag_vert_next   = flag_vert;
    wr               = 1'b0;

    if (item.opcode == ocd_pkg::OP_STOP) begin
      cmd_mode_next  = 1'b0;
      data_mode_next = 1'b0;
      cont_next      = 1'b0;
    end else if (!cmd_mode && !data_mode) begin
      // Control byte; anything else out of mode is dropped
      if (b[5:0] == 6'd0) begin
        cont_next = ~b[7];
        if (b[6:0] == 7'd0) begin
          cmd_mode_next = 1'b1;
        end else begin
          data_mode_next = 1'b1;
        end
      end
    end else begin
      if (cmd_mode) begin
        if (pending != 3'd0) begin
          // Argument byte of the last command
          case (last_cmd) inside
            ocd_pkg::CMD_ADDR_MODE: begin
              addr_mode_next = b;
            end
            ocd_pkg::CMD_COL_WINDOW: begin
              if (pending == ocd_pkg::ARGS_WINDOW) begin
                col_start_next = b[6:0];
              end else begin
                col_end_next = b[6:0];
              end
            end
            ocd_pkg::CMD_PAGE_WINDOW: begin
              if (pending == ocd_pkg::ARGS_WINDOW) begin
                page_start_next = b[2:0];
              end else begin
                page_end_next = (b[2:0] > page_lim) ? page_lim : b[2:0];
              end
            end
            ocd_pkg::CMD_SCROLL_RIGHT, ocd_pkg::CMD_SCROLL_LEFT: begin
              flag_vert_next  = 1'b0;
              flag_right_next = (last_cmd == ocd_pkg::CMD_SCROLL_RIGHT);
              if (pending == ocd_pkg::AT_HSCROLL_IVL) begin
                period_next = ocd_pkg::scroll_frames(b[2:0]);
              end
            end
            ocd_pkg::CMD_SCROLL_VRIGHT, ocd_pkg::CMD_SCROLL_VLEFT: begin
              flag_vert_next  = 1'b1;
              flag_right_next = (last_cmd == ocd_pkg::CMD_SCROLL_VRIGHT);
              if (pending == ocd_pkg::AT_VSCROLL_IVL) begin
                period_next = ocd_pkg::scroll_frames(b[2:0]);
              end
            end
            default: begin
            end
          endcase
          pending_next = pending - 3'd1;
        end else begin
          last_cmd_next = b;
          case (b) inside
            [ocd_pkg::CMD_COL_LOW_FIRST:ocd_pkg::CMD_COL_LOW_LAST]: begin
              col_ptr_next = {col_ptr[6:4], b[3:0]};
            end
            [ocd_pkg::CMD_COL_HIGH_FIRST:ocd_pkg::CMD_COL_HIGH_LAST]: begin
              col_ptr_next = {b[2:0], col_ptr[3:0]};
            end
            ocd_pkg::CMD_ADDR_MODE: begin
              pending_next = ocd_pkg::ARGS_ONE;
            end
            ocd_pkg::CMD_COL_WINDOW, ocd_pkg::CMD_PAGE_WINDOW,
            ocd_pkg::CMD_VSCROLL_AREA: begin
              pending_next = ocd_pkg::ARGS_WINDOW;
            end
            ocd_pkg::CMD_SCROLL_RIGHT, ocd_pkg::CMD_SCROLL_LEFT: begin
              pending_next = ocd_pkg::ARGS_HSCROLL;
            end
            ocd_pkg::CMD_SCROLL_VRIGHT, ocd_pkg::CMD_SCROLL_VLEFT: begin
              pending_next = ocd_pkg::ARGS_VSCROLL;
            end
            ocd_pkg::CMD_SCROLL_STOP: begin
              flag_scroll_next = 1'b0;
            end
            ocd_pkg::CMD_SCROLL_START: begin
              flag_scroll_next = 1'b1;
            end
            [ocd_pkg::CMD_LINE_FIRST:ocd_pkg::CMD_LINE_LAST]: begin
              line_start_next = b[5:0];
            end
            ocd_pkg::CMD_CONTRAST, ocd_pkg::CMD_CHARGE_PUMP, ocd_pkg::CMD_MUX_RATIO,
            ocd_pkg::CMD_DISP_OFFSET, ocd_pkg::CMD_CLOCK_DIV, ocd_pkg::CMD_PRECHARGE,
            ocd_pkg::CMD_COM_PINS, ocd_pkg::CMD_VCOM_LEVEL: begin
              pending_next = ocd_pkg::ARGS_ONE;
            end
            ocd_pkg::CMD_FOLLOW_RAM: begin
              flag_full_next = 1'b0;
            end
            ocd_pkg::CMD_ALL_ON: begin
              flag_full_next = 1'b1;
            end
            ocd_pkg::CMD_NORMAL: begin
              flag_invert_next = 1'b0;
            end
            ocd_pkg::CMD_INVERT: begin
              flag_invert_next = 1'b1;
            end
            ocd_pkg::CMD_DISPLAY_OFF: begin
              // Back to power-up settings, but the page window end follows page_count; modes and addressing mode stay
              col_ptr_next     = 7'd0;
              page_ptr_next    = 3'd0;
              col_start_next   = 7'd0;
              col_end_next     = ColLast;
              page_start_next  = 3'd0;
              page_end_next    = page_lim;
              period_next      = ocd_pkg::PERIOD_RESET;
              line_start_next  = 6'd0;
              pending_next     = 3'd0;
              flag_on_next     = 1'b0;
              flag_full_next   = 1'b0;
              flag_invert_next = 1'b0;
              flag_scroll_next = 1'b0;
              flag_right_next  = 1'b0;
              flag_vert_next   = 1'b0;
            end
            ocd_pkg::CMD_DISPLAY_ON: begin
              flag_on_next = 1'b1;
            end
            [ocd_pkg::CMD_PAGE_FIRST:ocd_pkg::CMD_PAGE_LAST]: begin
              page_ptr_next = b[2:0];
            end
            default: begin
            end
          endcase
        end
      end else begin
        wr            = 1'b1;
        col_ptr_next  = col_adv[6:0];
        page_ptr_next = page_adv[2:0];
      end
      if (!cont) begin
        cmd_mode_next  = 1'b0;
        data_mode_next = 1'b0;
      end
    end
  end

  always_comb begin
    result.ram_write        = wr;
    result.write_column     = wr ? col_ptr : 7'd0;
    result.write_page       = wr ? page_ptr : 3'd0;
    result.write_data       = wr ? b : 8'd0;
    result.display_on       = flag_on_next;
    result.display_full     = flag_full_next;
    result.display_inverted = flag_invert_next;
    result.start_line       = line_start_next;
    result.scroll_active    = flag_scroll_next;
    result.scroll_right     = flag_right_next;
    result.scroll_vertical  = flag_vert_next;
    result.scroll_interval  = period_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_mode    <= 1'b0;
      data_mode   <= 1'b0;
      cont        <= 1'b0;
      pending     <= 3'd0;
      last_cmd    <= 8'd0;
      addr_mode   <= ocd_pkg::MODE_HORIZONTAL;
      col_ptr     <= 7'd0;
      page_ptr    <= 3'd0;
      col_start   <= 7'd0;
      col_end     <= ColLast;
      page_start  <= 3'd0;
      page_end    <= ocd_pkg::last_page(ocd_pkg::PAGE_COUNT_RESET);
      period      <= ocd_pkg::PERIOD_RESET;
      line_start  <= 6'd0;
      flag_on     <= 1'b0;
      flag_full   <= 1'b0;
      flag_invert <= 1'b0;
      flag_scroll <= 1'b0;
      flag_right  <= 1'b0;
      flag_vert   <= 1'b0;
    end else if (fire) begin
      cmd_mode    <= cmd_mode_next;
      data_mode   <= data_mode_next;
      cont        <= cont_next;
      pending     <= pending_next;
      last_cmd    <= last_cmd_next;
      addr_mode   <= addr_mode_next;
      col_ptr     <= col_ptr_next;
      page_ptr    <= page_ptr_next;
      col_start   <= col_start_next;
      col_end     <= col_end_next;
      page_start  <= page_start_next;
      page_end    <= page_end_next;
      period      <= period_next;
      line_start  <= line_start_next;
      flag_on     <= flag_on_next;
      flag_full   <= flag_full_next;
      flag_invert <= flag_invert_next;
      flag_scroll <= flag_scroll_next;
      flag_right  <= flag_right_next;
      flag_vert   <= flag_vert_next;
    end
  end

endmodule

[rtl/oled_command_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_command_decoder
// Decodes bus bytes and stop events into display memory writes and settings.
// ----------------------------------------------------------------------------
// One transfer on req gives exactly one transfer on rsp. A byte is held in an
// input register, decoded combinationally against the decoder state and
// landed in the response register, so a new byte is taken every cycle while
// rsp keeps draining; rsp_valid rises once the byte has passed the input
// register and the response register, later only while rsp stalls.
// The user must write the page_count register through cfg only while the
// block is idle; the block does not enforce this. It is used by the page
// window and display-off commands; after reset the window end is always 7.
module oled_command_decoder #(
  parameter int COLUMNS = ocd_pkg::COLUMNS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ocd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ocd_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_data
);

  logic          hold_valid;
  ocd_pkg::req_t hold;
  logic          take;
  logic [3:0]    page_count;
  ocd_pkg::rsp_t result;

  // Advance the held byte whenever the response slot is free or draining
  assign take      = hold_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !hold_valid || take;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= ocd_pkg::PAGE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      page_count <= cfg_data;
    end
  end

  ocd_ctrl #(
    .COLUMNS(COLUMNS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (take),
    .item       (hold),
    .page_count (page_count),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= result;
    end
  end

endmodule
